### src/rrcs_pkg.sv
// Package for the round-robin clock-sync master.
// Holds the word types, opcode and result-kind codes and the output queue depth.
// No dependencies.
`timescale 1ns / 1ps

package rrcs_pkg;

    // Opcodes of the input word.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_PONG  = 3'd1;
    localparam logic [2:0] OP_TIME  = 3'd2;
    localparam logic [2:0] OP_DRIFT = 3'd3;
    localparam logic [2:0] OP_START = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // Kinds of the result word.
    localparam logic [2:0] K_PING  = 3'd0;
    localparam logic [2:0] K_CORR  = 3'd1;
    localparam logic [2:0] K_TIME  = 3'd2;
    localparam logic [2:0] K_DRIFT = 3'd3;
    localparam logic [2:0] K_START = 3'd4;
    localparam logic [2:0] K_STOP  = 3'd5;
    localparam logic [2:0] K_MISS  = 3'd6;

    // Result queue: room for two words per item plus two in flight.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now;
        logic [7:0]  pong_node;
        logic [31:0] remote_stamp;
        logic [31:0] command_arg;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  node;
        logic [31:0] payload;
        logic        last;
    } t_out_word;

    // Words produced by one item: zero, one or two of them.
    typedef struct packed {
        logic [1:0] num;
        t_out_word  w0;
        t_out_word  w1;
    } t_push;

endpackage

### src/rrcs_core.sv
// Processing stage of the round-robin clock-sync master: node register,
// round statistics, correction arithmetic and result word generation.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps

module rrcs_core #(
    parameter int MAX_NODES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    input  logic              i_fire,
    input  rrcs_pkg::t_in_word i_item,
    output rrcs_pkg::t_push   o_push
);

    // Largest node count that can take effect, and the width of a node index.
    localparam int CNT_MAX = (MAX_NODES < 511) ? MAX_NODES : 511;
    localparam int NODE_W  = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    logic [8:0]        r_node_count;
    logic [NODE_W-1:0] r_cur;
    logic              r_started;
    logic [31:0]       r_ping_time;
    logic              r_pong_seen;
    logic [31:0]       r_latest;
    logic [31:0]       r_min;
    logic [31:0]       r_max;
    logic [31:0]       r_drift;

    logic [9:0]  w_cnt;
    logic [9:0]  w_cur_ext;
    logic [9:0]  w_next;
    logic [9:0]  w_ping_node;
    logic        w_wrap;
    logic        w_miss;
    logic        w_fold;
    logic [31:0] n_min;
    logic [31:0] n_max;
    logic        w_match;
    logic [31:0] w_half;
    logic [31:0] w_corr;
    logic        w_is_tick;
    logic        w_is_pong;
    rrcs_pkg::t_out_word w_ping;

    // Effective node count: zero counts as one, large values saturate.
    always_comb begin
        if (r_node_count == 9'd0) begin
            w_cnt = 10'd1;
        end else if (32'(r_node_count) > 32'(CNT_MAX)) begin
            w_cnt = 10'(CNT_MAX);
        end else begin
            w_cnt = 10'(r_node_count);
        end
    end

    // Tick: fold the last correction, step to the next node, wrap the round.
    assign w_cur_ext   = 10'(r_cur);
    assign w_miss      = r_started && !r_pong_seen;
    assign w_fold      = r_started && r_pong_seen;
    assign w_next      = r_started ? (w_cur_ext + 10'd1) : 10'd0;
    assign w_wrap      = (w_next >= w_cnt);
    assign w_ping_node = w_wrap ? 10'd0 : w_next;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (w_fold) begin
            if ((w_cur_ext == 10'd0) || ($signed(r_latest) < $signed(r_min))) begin
                n_min = r_latest;
            end
            if ((w_cur_ext == 10'd0) || ($signed(r_max) < $signed(r_latest))) begin
                n_max = r_latest;
            end
        end
    end

    // Pong: remote time estimate is reported time plus half the round trip.
    assign w_match = r_started && (w_cur_ext == {2'b00, i_item.pong_node});
    assign w_half  = (i_item.now - r_ping_time) >> 1;
    assign w_corr  = i_item.now - (i_item.remote_stamp + w_half);

    assign w_is_tick = i_fire && (i_item.opcode == rrcs_pkg::OP_TICK);
    assign w_is_pong = i_fire && (i_item.opcode == rrcs_pkg::OP_PONG) && w_match;

    assign w_ping = '{kind: rrcs_pkg::K_PING, node: w_ping_node[7:0],
                      payload: 32'd0, last: 1'b1};

    // Result words for the item in the input register.
    always_comb begin
        o_push    = '0;
        o_push.w0 = w_ping;
        o_push.w1 = w_ping;
        if (i_fire) begin
            unique case (i_item.opcode)
                rrcs_pkg::OP_TICK: begin
                    if (w_miss) begin
                        o_push.num = 2'd2;
                        o_push.w0  = '{kind: rrcs_pkg::K_MISS, node: w_cur_ext[7:0],
                                       payload: 32'd0, last: 1'b0};
                    end else begin
                        o_push.num = 2'd1;
                    end
                end
                rrcs_pkg::OP_PONG: begin
                    if (w_match) begin
                        o_push.num = 2'd1;
                        o_push.w0  = '{kind: rrcs_pkg::K_CORR, node: w_cur_ext[7:0],
                                       payload: w_corr, last: 1'b1};
                    end
                end
                rrcs_pkg::OP_TIME: begin
                    o_push.num = 2'd1;
                    o_push.w0  = '{kind: rrcs_pkg::K_TIME, node: 8'd0,
                                   payload: i_item.now, last: 1'b1};
                end
                rrcs_pkg::OP_DRIFT: begin
                    o_push.num = 2'd1;
                    o_push.w0  = '{kind: rrcs_pkg::K_DRIFT, node: 8'd0,
                                   payload: r_drift, last: 1'b1};
                end
                rrcs_pkg::OP_START: begin
                    o_push.num = 2'd1;
                    o_push.w0  = '{kind: rrcs_pkg::K_START, node: 8'd0,
                                   payload: i_item.command_arg, last: 1'b1};
                end
                rrcs_pkg::OP_STOP: begin
                    o_push.num = 2'd1;
                    o_push.w0  = '{kind: rrcs_pkg::K_STOP, node: 8'd0,
                                   payload: i_item.command_arg, last: 1'b1};
                end
                default: begin
                    o_push.num = 2'd0;
                end
            endcase
        end
    end

    // Configuration and sync state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 9'd1;
            r_cur        <= '0;
            r_started    <= 1'b0;
            r_ping_time  <= '0;
            r_pong_seen  <= 1'b0;
            r_latest     <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_drift      <= '1;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (w_is_tick) begin
                r_min       <= n_min;
                r_max       <= n_max;
                r_cur       <= NODE_W'(w_ping_node);
                r_started   <= 1'b1;
                r_ping_time <= i_item.now;
                r_pong_seen <= 1'b0;
                if (w_wrap) begin
                    r_drift <= n_max - n_min;
                end
            end
            if (w_is_pong) begin
                r_latest    <= w_corr;
                r_pong_seen <= 1'b1;
            end
        end
    end

endmodule

### src/rrcs_out_fifo.sv
// Result queue of the round-robin clock-sync master: takes up to two words
// per cycle and presents one word a cycle on the output channel when not stalled.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps

module rrcs_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrcs_pkg::t_push     i_push,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output rrcs_pkg::t_out_word o_out_word,
    output logic                o_room
);

    rrcs_pkg::t_out_word r_mem [rrcs_pkg::FIFO_DEPTH];
    logic [rrcs_pkg::FIFO_PTR_W-1:0] r_wr;
    logic [rrcs_pkg::FIFO_PTR_W-1:0] r_rd;
    logic [rrcs_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic                            w_pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_mem[r_rd];
    assign w_pop       = o_out_valid && !i_out_stall;
    // Room for a full item regardless of what leaves this cycle.
    assign o_room      = (r_cnt <= rrcs_pkg::FIFO_CNT_W'(rrcs_pkg::FIFO_DEPTH - 2));

    // Word storage.
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + rrcs_pkg::FIFO_PTR_W'(1)] <= i_push.w1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + rrcs_pkg::FIFO_PTR_W'(i_push.num);
            r_rd  <= r_rd + rrcs_pkg::FIFO_PTR_W'(w_pop);
            r_cnt <= r_cnt + rrcs_pkg::FIFO_CNT_W'(i_push.num)
                           - rrcs_pkg::FIFO_CNT_W'(w_pop);
        end
    end

endmodule

### src/round_robin_clock_sync_master.sv
// Top level of the round-robin clock-sync master.
// Depends on rrcs_pkg, rrcs_core and rrcs_out_fifo.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+--------------------
//  input   | in        | i_in_valid / o_in_stall      | rrcs_pkg::t_in_word
//  result  | out       | o_out_valid / i_out_stall    | rrcs_pkg::t_out_word
//  config  | in        | i_cfg_we                     | i_cfg_wdata (node count)
//
// One input word is taken per cycle unless the input stalls; it waits in the
// input register, then the processing stage writes its results to the result queue.
// A tick that reports a missed pong yields two words, so the output side sets
// the rate then: one result word per cycle unless stalled, out of a four-word queue.
// The input stalls while a word is held and the queue holds more than two words.
// Reset is synchronous and clears the queue, the input valid flag and the sync
// state; the drift range reads as all ones until the first round ends.
`timescale 1ns / 1ps

module round_robin_clock_sync_master #(
    parameter int MAX_NODES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrcs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrcs_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata
);

    logic               r_in_valid;
    rrcs_pkg::t_in_word r_in;
    logic               w_room;
    logic               w_fire;
    rrcs_pkg::t_push    w_push;

    // The held word moves on when the queue has room for its results.
    assign w_fire     = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    rrcs_core #(
        .MAX_NODES (MAX_NODES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .o_push      (w_push)
    );

    rrcs_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_room      (w_room)
    );

endmodule

### src/rrcs_checker.sv
// Port checker for the round-robin clock-sync master, with its bind.
// Depends on rrcs_pkg and round_robin_clock_sync_master.
`timescale 1ns / 1ps

module rrcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rrcs_pkg::t_out_word o_out_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // Reset leaves nothing pending on either side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not clear after reset");

    // Only a missed-pong report is followed by another word of the same item.
    a_last_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.last == (o_out_word.kind != rrcs_pkg::K_MISS)))
        else $error("last flag does not match result kind");

    // A missed-pong report is followed at once by the ping of that tick.
    a_miss_then_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_out_word.kind == rrcs_pkg::K_MISS))
        |=> (o_out_valid && (o_out_word.kind == rrcs_pkg::K_PING)))
        else $error("missed-pong report not followed by a ping");

endmodule

bind round_robin_clock_sync_master rrcs_checker u_rrcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
